@@ src/tbps_pkg.sv @@
// Types and constants shared by the token-bucket shaper modules.
// No dependencies.
package tbps_pkg;

  localparam int RATE_W     = 17;
  localparam int TIMEOUT_W  = 24;
  localparam int BURST_W    = 17;
  localparam int MINB_W     = 21;
  localparam int QBYTES_W   = 25;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_RATE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_RATE       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FEEDBACK_TIMEOUT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_TIME      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BURST       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_QUEUE       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MARK_THRESHOLD  = 3'd7;

  localparam logic [1:0] CMD_ENQ        = 2'd0;
  localparam logic [1:0] CMD_REFILL_DEQ = 2'd1;

  localparam logic [1:0] KIND_VERDICT = 2'd0;
  localparam logic [1:0] KIND_TX      = 2'd1;
  localparam logic [1:0] KIND_NONE    = 2'd2;

  localparam logic [RATE_W-1:0]     RST_INITIAL_RATE  = 17'd1000;
  localparam logic [TIMEOUT_W-1:0]  RST_IDLE_TIMEOUT  = 24'd100000;
  localparam logic [RATE_W-1:0]     RST_IDLE_RATE     = 17'd100;
  localparam logic [TIMEOUT_W-1:0]  RST_FB_TIMEOUT    = 24'd100000;
  localparam logic [BURST_W-1:0]    RST_BURST_TIME    = 17'd500;
  localparam logic [MINB_W-1:0]     RST_MIN_BURST     = 21'd65536;
  localparam logic [QBYTES_W-1:0]   RST_MAX_QUEUE     = 25'd262144;
  localparam logic [QBYTES_W-1:0]   RST_MARK_THRESHOLD = 25'd131072;
  localparam logic [31:0]           RST_POOL_TOKENS   = 32'd15000;
  localparam logic [RATE_W-1:0]     MIN_RATE          = 17'd2;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] now_us;
    logic [15:0] pkt_len;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        dropped;
    logic        mark_congestion;
    logic [15:0] tx_len;
    logic        rearm_timer;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic rate_step;
    logic mul_step;
    logic mul_sel;
    logic pool_step;
    logic enq_step;
    logic borrow_step;
    logic test_step;
    logic flush_step;
  } dp_cmd_t;

  typedef struct packed {
    logic slot_free;
    logic count_zero;
    logic count_one;
    logic pass;
  } dp_stat_t;

endpackage

@@ src/tbps_stream_if.sv @@
// Valid/ready channel carrying one payload struct.
// Payload type comes from tbps_pkg at the instance.
interface tbps_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ src/tbps_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tbps_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/tbps_datapath.sv @@
// Shaper datapath: config registers, token state, shared multiplier,
// length FIFO and result register. Uses tbps_pkg, tbps_ram, tbps_stream_if.
module tbps_datapath #(
  parameter int QUEUE_DEPTH = 64,
  parameter int LEN_BITS    = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]      cfg_addr,
  input  logic [tbps_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  tbps_pkg::in_item_t                  in_item,
  input  tbps_pkg::dp_cmd_t                   cmd,
  output tbps_pkg::dp_stat_t                  stat,
  tbps_stream_if.source                       rsp
);
  import tbps_pkg::*;

  localparam int AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW    = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W = LEN_BITS + AW + 1;

  // configuration
  logic [TIMEOUT_W-1:0] idle_timeout;
  logic [RATE_W-1:0]    idle_rate;
  logic [TIMEOUT_W-1:0] fb_timeout;
  logic [BURST_W-1:0]   burst_time;
  logic [MINB_W-1:0]    min_burst;
  logic [QBYTES_W-1:0]  max_queue;
  logic [QBYTES_W-1:0]  mark_thr;

  // token and queue state
  logic [RATE_W-1:0]   current_rate;
  logic [31:0]         pool_tokens;
  logic [31:0]         queue_tokens;
  logic [31:0]         last_refill;
  logic [31:0]         last_rate;
  logic [LEN_BITS-1:0] head_len;
  logic [QBYTES_W-1:0] queued_bytes;
  logic [CW-1:0]       fifo_count;
  logic [AW-1:0]       rd_ptr;

  // per-request working registers
  logic [31:0]         now_us;
  logic [LEN_BITS-1:0] pkt_len;
  logic [31:0]         elapsed;
  logic [45:0]         add_tok;
  logic [30:0]         cap_raw;
  logic [SUM_W-1:0]    burst_sum;
  logic                pend;
  logic [LEN_BITS-1:0] pend_len;

  logic                out_valid;
  out_item_t           out_data;

  // combinational
  logic [31:0]         us, us2;
  logic [RATE_W-1:0]   rate_a, rate_h, rate_b;
  logic [31:0]         mul_op;
  logic [48:0]         product;
  logic [30:0]         cap;
  logic [46:0]         total;
  logic [QBYTES_W:0]   qsum;
  logic                drop;
  logic [AW:0]         wsum;
  logic [AW-1:0]       wr_addr;
  logic [32:0]         borrow_sum;
  logic [LEN_BITS-1:0] size;
  logic [SUM_W-1:0]    sum_new;
  logic                pass;
  logic                emit;
  out_item_t           emit_data;

  always_comb begin
    us     = now_us - last_refill;
    us2    = now_us - last_rate;
    rate_a = (us > 32'(idle_timeout) && current_rate > idle_rate) ? idle_rate : current_rate;
    rate_h = rate_a >> 1;
    rate_b = (rate_h < MIN_RATE) ? MIN_RATE : rate_h;
    mul_op = cmd.mul_sel ? 32'(burst_time) : elapsed;
    product = 49'(current_rate) * 49'(mul_op);
    cap    = (cap_raw < 31'(min_burst)) ? 31'(min_burst) : cap_raw;
    total  = 47'(pool_tokens) + 47'(add_tok);
    qsum   = (QBYTES_W + 1)'(queued_bytes) + (QBYTES_W + 1)'(pkt_len);
    drop   = (qsum > (QBYTES_W + 1)'(max_queue)) || (fifo_count >= CW'(QUEUE_DEPTH));
    wsum   = (AW + 1)'(rd_ptr) + (AW + 1)'(fifo_count);
    wr_addr = (wsum >= (AW + 1)'(QUEUE_DEPTH)) ? AW'(wsum - (AW + 1)'(QUEUE_DEPTH))
                                               : AW'(wsum);
    borrow_sum = 33'(queue_tokens) + 33'(pool_tokens);
    sum_new = pend ? burst_sum + SUM_W'(size) : SUM_W'(size);
    pass   = (32'(size) <= queue_tokens) &&
             (32'(sum_new) <= {10'b0, min_burst, 1'b0});
  end

  tbps_ram #(.WIDTH(LEN_BITS), .DEPTH(QUEUE_DEPTH)) u_fifo_ram (
    .clk   (clk),
    .we    (cmd.enq_step && !drop),
    .waddr (wr_addr),
    .wdata (pkt_len),
    .raddr (rd_ptr),
    .rdata (size)
  );

  // result selection
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    if (cmd.enq_step) begin
      emit                      = 1'b1;
      emit_data.kind            = KIND_VERDICT;
      emit_data.dropped         = drop;
      emit_data.mark_congestion = !drop && (qsum > (QBYTES_W + 1)'(mark_thr));
      emit_data.last            = 1'b1;
    end else if (cmd.borrow_step) begin
      if (fifo_count == '0) begin
        emit           = 1'b1;
        emit_data.kind = KIND_NONE;
        emit_data.last = 1'b1;
      end
    end else if (cmd.test_step) begin
      if (pass) begin
        // hand on the previous packet, hold this one until its successor is judged or it is flushed
        emit             = pend;
        emit_data.kind   = KIND_TX;
        emit_data.tx_len = 16'(pend_len);
      end else begin
        emit                  = 1'b1;
        emit_data.kind        = pend ? KIND_TX : KIND_NONE;
        emit_data.tx_len      = pend ? 16'(pend_len) : 16'd0;
        emit_data.rearm_timer = 1'b1;
        emit_data.last        = 1'b1;
      end
    end else if (cmd.flush_step) begin
      emit             = 1'b1;
      emit_data.kind   = KIND_TX;
      emit_data.tx_len = 16'(pend_len);
      emit_data.last   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout <= RST_IDLE_TIMEOUT;
      idle_rate    <= RST_IDLE_RATE;
      fb_timeout   <= RST_FB_TIMEOUT;
      burst_time   <= RST_BURST_TIME;
      min_burst    <= RST_MIN_BURST;
      max_queue    <= RST_MAX_QUEUE;
      mark_thr     <= RST_MARK_THRESHOLD;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_IDLE_TIMEOUT:     idle_timeout <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_IDLE_RATE:        idle_rate    <= cfg_wdata[RATE_W-1:0];
        CFG_FEEDBACK_TIMEOUT: fb_timeout   <= cfg_wdata[TIMEOUT_W-1:0];
        CFG_BURST_TIME:       burst_time   <= cfg_wdata[BURST_W-1:0];
        CFG_MIN_BURST:        min_burst    <= cfg_wdata[MINB_W-1:0];
        CFG_MAX_QUEUE:        max_queue    <= cfg_wdata[QBYTES_W-1:0];
        CFG_MARK_THRESHOLD:   mark_thr     <= cfg_wdata[QBYTES_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_rate <= RST_INITIAL_RATE;
      last_rate    <= '0;
    end else if (cfg_wr_en && cfg_addr == CFG_INITIAL_RATE) begin
      current_rate <= cfg_wdata[RATE_W-1:0];
    end else if (cmd.rate_step) begin
      if (us2 > 32'(fb_timeout)) begin
        current_rate <= rate_b;
        last_rate    <= now_us;
      end else begin
        current_rate <= rate_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_tokens  <= RST_POOL_TOKENS;
      queue_tokens <= '0;
      last_refill  <= '0;
      head_len     <= '0;
      queued_bytes <= '0;
      fifo_count   <= '0;
      rd_ptr       <= '0;
      pend         <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.pool_step) begin
        pool_tokens <= (total > 47'(cap)) ? 32'(cap) : total[31:0];
        last_refill <= now_us;
      end
      if (cmd.enq_step && !drop) begin
        fifo_count   <= fifo_count + 1'b1;
        queued_bytes <= qsum[QBYTES_W-1:0];
      end
      if (cmd.borrow_step) begin
        pend <= 1'b0;
        if (queue_tokens < 32'(head_len)) begin
          queue_tokens <= borrow_sum[32] ? '1 : borrow_sum[31:0];
          pool_tokens  <= '0;
        end
      end
      if (cmd.test_step) begin
        head_len <= size;
        if (pass) begin
          queue_tokens <= queue_tokens - 32'(size);
          queued_bytes <= (queued_bytes >= QBYTES_W'(size)) ? queued_bytes - QBYTES_W'(size)
                                                             : '0;
          rd_ptr       <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
          fifo_count   <= fifo_count - 1'b1;
          pend         <= 1'b1;
        end else begin
          pend <= 1'b0;
        end
      end
      if (cmd.flush_step) begin
        pend <= 1'b0;
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_us   <= in_item.now_us;
      pkt_len  <= LEN_BITS'(in_item.pkt_len);
    end
    if (cmd.rate_step) begin
      elapsed <= us;
    end
    if (cmd.mul_step) begin
      if (cmd.mul_sel) begin
        cap_raw <= product[33:3];
      end else begin
        add_tok <= product[48:3];
      end
    end
    if (cmd.test_step) begin
      burst_sum <= sum_new;
      if (pass) begin
        pend_len <= size;
      end
    end
    if (emit) begin
      out_data <= emit_data;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  always_comb begin
    stat.slot_free  = !out_valid || rsp.ready;
    stat.count_zero = (fifo_count == '0);
    stat.count_one  = (fifo_count == CW'(1));
    stat.pass       = pass;
  end
endmodule

@@ src/tbps_ctrl.sv @@
// Shaper controller: sequences refill, enqueue and the dequeue walk.
// Uses tbps_pkg; drives the datapath through dp_cmd_t.
module tbps_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [1:0]          in_cmd,
  output logic                in_ready,
  input  tbps_pkg::dp_stat_t  stat,
  output tbps_pkg::dp_cmd_t   cmd
);
  import tbps_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_RATE      = 10'b0000000010,
    S_MUL_US    = 10'b0000000100,
    S_MUL_BURST = 10'b0000001000,
    S_POOL      = 10'b0000010000,
    S_ENQ       = 10'b0000100000,
    S_BORROW    = 10'b0001000000,
    S_READ      = 10'b0010000000,
    S_TEST      = 10'b0100000000,
    S_FLUSH     = 10'b1000000000
  } state_t;

  state_t state, state_next;
  logic   enq_flag;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = (in_cmd == CMD_ENQ || in_cmd == CMD_REFILL_DEQ) ? S_RATE : S_BORROW;
        end
      end
      S_RATE: begin
        cmd.rate_step = 1'b1;
        state_next    = S_MUL_US;
      end
      S_MUL_US: begin
        cmd.mul_step = 1'b1;
        state_next   = S_MUL_BURST;
      end
      S_MUL_BURST: begin
        cmd.mul_step = 1'b1;
        cmd.mul_sel  = 1'b1;
        state_next   = S_POOL;
      end
      S_POOL: begin
        cmd.pool_step = 1'b1;
        state_next    = enq_flag ? S_ENQ : S_BORROW;
      end
      S_ENQ: begin
        if (stat.slot_free) begin
          cmd.enq_step = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_BORROW: begin
        if (stat.slot_free) begin
          cmd.borrow_step = 1'b1;
          state_next      = stat.count_zero ? S_IDLE : S_READ;
        end
      end
      S_READ: begin
        // wait out the FIFO read latency
        state_next = S_TEST;
      end
      S_TEST: begin
        if (stat.slot_free) begin
          cmd.test_step = 1'b1;
          if (!stat.pass) begin
            state_next = S_IDLE;
          end else if (stat.count_one) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_READ;
          end
        end
      end
      S_FLUSH: begin
        if (stat.slot_free) begin
          cmd.flush_step = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      enq_flag <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_valid) begin
        enq_flag <= (in_cmd == CMD_ENQ);
      end
    end
  end
endmodule

@@ src/token_bucket_packet_shaper.sv @@
// Token-bucket packet shaper, top level: controller plus datapath.
// Uses tbps_pkg, tbps_stream_if, tbps_ctrl, tbps_datapath.
//
// One request at a time. An enqueue runs the refill and then appends the
// packet; refill then dequeue runs the refill and then the dequeue walk,
// which judges one packet at a time and ends with a flush step when it
// empties the queue; dequeue only runs the walk alone. The refill spends
// one step on the rate update and then runs its two products through one
// shared multiplier, and each packet of the dequeue walk waits on the
// registered read of the length RAM. Results leave through a single output
// register; the next request is taken while the last result of the previous
// one is still waiting there.
module token_bucket_packet_shaper #(
  parameter int QUEUE_DEPTH = 64,
  parameter int LEN_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [tbps_pkg::CFG_IDX_W-1:0]  cfg_addr,
  input  logic [tbps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  tbps_stream_if.sink                     req,
  tbps_stream_if.source                   rsp
);
  import tbps_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  in_item_t in_item;

  assign in_item = req.data;

  tbps_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_cmd   (in_item.cmd),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tbps_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH), .LEN_BITS(LEN_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .rsp       (rsp)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request taken while previous one still in progress");

  a_verdict_is_last: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.kind == KIND_VERDICT |-> rsp.data.last)
    else $error("enqueue verdict not marked last");

  a_nonlast_is_tx: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.data.last |-> rsp.data.kind == KIND_TX && !rsp.data.rearm_timer)
    else $error("intermediate result is not a plain transmit");
endmodule
